// ----- hdl/rbe_pkg.sv -----
// shared types and constants for the register bytecode executor
// no dependencies; imported by every module of the block
package rbe_pkg;

  // datapath geometry
  localparam int DATA_WIDTH = 64;
  localparam int NUM_REGS   = 16;
  localparam int REG_AW     = 4;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int IMM_W      = 8;

  // opcodes carried on func
  localparam logic [3:0] OP_IMM   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_MOVE  = 4'd5;
  localparam logic [3:0] OP_DONE  = 4'd6;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_DIV0    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // operation of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  // request to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // register file write port
  typedef struct packed {
    logic                  en;
    logic [REG_AW-1:0]     addr;
    logic [DATA_WIDTH-1:0] data;
  } rf_wr_t;

endpackage

// ----- hdl/rbe_regfile.sv -----
// sixteen-entry register file, one write port and two registered read ports
// depends on rbe_pkg; per-entry valid bits make unwritten entries read as zero
module rbe_regfile import rbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  rf_wr_t                wr,
  input  logic [REG_AW-1:0]     rd_a_addr,
  input  logic [REG_AW-1:0]     rd_b_addr,
  output logic [DATA_WIDTH-1:0] rd_a_data,
  output logic [DATA_WIDTH-1:0] rd_b_data
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   valid;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rd_a_data <= valid[rd_a_addr] ? mem[rd_a_addr] : '0;
    rd_b_data <= valid[rd_b_addr] ? mem[rd_b_addr] : '0;
  end

endmodule

// ----- hdl/rbe_alu.sv -----
// shared iterative arithmetic unit: add, subtract, shift-add multiply,
// restoring divide, all on one adder; depends on rbe_pkg
module rbe_alu import rbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  alu_req_t              req,
  input  logic [DATA_WIDTH-1:0] opa,
  input  logic [DATA_WIDTH-1:0] opb,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  typedef enum logic [1:0] {
    A_IDLE = 2'b01,
    A_RUN  = 2'b10
  } alu_state_t;

  alu_state_t            state;
  alu_op_t               op_r;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] breg;
  logic [DATA_WIDTH-1:0] qreg;
  logic [CNT_W-1:0]      count;

  logic [DATA_WIDTH:0]   add_x;
  logic [DATA_WIDTH:0]   add_y;
  logic                  add_sub;
  logic [DATA_WIDTH+1:0] add_sum;
  logic                  carry;

  // operand selection for the shared adder
  always_comb begin
    add_x   = {1'b0, acc};
    add_y   = {1'b0, breg};
    add_sub = 1'b0;
    unique case (op_r)
      ALU_ADD: add_sub = 1'b0;
      ALU_SUB: add_sub = 1'b1;
      ALU_MUL: add_sub = 1'b0;
      ALU_DIV: begin
        add_x   = {acc, qreg[DATA_WIDTH-1]};
        add_sub = 1'b1;
      end
      default: add_sub = 1'b0;
    endcase
  end

  // one adder, subtract by inversion and carry in
  assign add_sum = {1'b0, add_x}
                 + {1'b0, (add_sub ? ~add_y : add_y)}
                 + {{(DATA_WIDTH+1){1'b0}}, add_sub};
  assign carry   = add_sum[DATA_WIDTH+1];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: if (req.start) state <= A_RUN;
        A_RUN: begin
          if (count == '0) begin
            state <= A_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == A_IDLE) begin
      if (req.start) begin
        op_r <= req.op;
        unique case (req.op)
          ALU_ADD, ALU_SUB: begin
            acc   <= opa;
            breg  <= opb;
            count <= '0;
          end
          ALU_MUL: begin
            acc   <= '0;
            breg  <= opa;
            qreg  <= opb;
            count <= CNT_W'(DATA_WIDTH - 1);
          end
          ALU_DIV: begin
            acc   <= '0;
            breg  <= opb;
            qreg  <= opa;
            count <= CNT_W'(DATA_WIDTH - 1);
          end
          default: count <= '0;
        endcase
      end
    end else begin
      count <= count - CNT_W'(1);
      unique case (op_r)
        ALU_ADD, ALU_SUB: acc <= add_sum[DATA_WIDTH-1:0];
        ALU_MUL: begin
          // add the shifted multiplicand when the multiplier bit is set
          if (qreg[0]) acc <= add_sum[DATA_WIDTH-1:0];
          breg <= {breg[DATA_WIDTH-2:0], 1'b0};
          qreg <= {1'b0, qreg[DATA_WIDTH-1:1]};
        end
        ALU_DIV: begin
          // restoring step: keep the difference when no borrow
          acc  <= carry ? add_sum[DATA_WIDTH-1:0] : add_x[DATA_WIDTH-1:0];
          qreg <= {qreg[DATA_WIDTH-2:0], carry};
        end
        default: acc <= acc;
      endcase
    end
  end

  assign result = (op_r == ALU_DIV) ? qreg : acc;

endmodule

// ----- hdl/register_bytecode_executor.sv -----
// Register bytecode executor: runs one 16-bit instruction per input transfer
// against sixteen DATA_WIDTH-bit registers and a result register, and returns
// a status with the result register. One instruction at a time; mul and div
// take longest, as the shared adder multiplies and divides one bit per cycle.
// The result sits in an output register, and the next instruction is accepted
// while it waits. Registers keep their values across programs; reset zeroes
// them at once.
// depends on rbe_pkg, rbe_regfile and rbe_alu
module register_bytecode_executor import rbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            func,
  input  logic [11:0]           operand_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [DATA_WIDTH-1:0] result_value
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                state;
  logic [3:0]            func_r;
  logic [11:0]           opnd_r;
  logic [1:0]            st_r;
  logic [DATA_WIDTH-1:0] result_reg;

  logic [REG_AW-1:0]     ra;
  logic [REG_AW-1:0]     rb;
  logic [REG_AW-1:0]     rc;
  logic [IMM_W-1:0]      imm;
  logic [DATA_WIDTH-1:0] va;
  logic [DATA_WIDTH-1:0] vb;
  logic                  vb_zero;
  rf_wr_t                wr;
  alu_req_t              alu_req;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;
  logic                  out_free;

  // operand fields
  assign ra  = opnd_r[11:8];
  assign rb  = opnd_r[7:4];
  assign rc  = opnd_r[3:0];
  assign imm = opnd_r[7:0];
  assign vb_zero = (vb == '0);

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  rbe_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd_a_addr (ra),
    .rd_b_addr (rb),
    .rd_a_data (va),
    .rd_b_data (vb)
  );

  rbe_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (va),
    .opb    (vb),
    .done   (alu_done),
    .result (alu_result)
  );

  // decode: arithmetic requests and register writes
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = ALU_ADD;
    wr.en         = 1'b0;
    wr.addr       = rc;
    wr.data       = alu_result;
    if (state == S_EXEC) begin
      unique case (func_r)
        OP_IMM: begin
          wr.en   = 1'b1;
          wr.addr = ra;
          wr.data = DATA_WIDTH'(imm);
        end
        OP_ADD: alu_req.start = 1'b1;
        OP_SUB: begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_SUB;
        end
        OP_MUL: begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_MUL;
        end
        OP_DIV: begin
          alu_req.start = !vb_zero;
          alu_req.op    = ALU_DIV;
        end
        default: alu_req.start = 1'b0;
      endcase
    end else if (state == S_WAIT) begin
      wr.en = alu_done;
    end
  end

  // instruction sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      result_reg <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          state <= alu_req.start ? S_WAIT : S_FINISH;
          if (func_r == OP_MOVE) result_reg <= va;
        end
        S_WAIT: if (alu_done) state <= S_FINISH;
        S_FINISH: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // instruction latch and status
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      func_r <= func;
      opnd_r <= operand_bits;
    end
    if (state == S_EXEC) begin
      unique case (func_r)
        OP_IMM, OP_ADD, OP_SUB, OP_MUL, OP_MOVE: st_r <= ST_OK;
        OP_DIV:  st_r <= vb_zero ? ST_DIV0 : ST_OK;
        OP_DONE: st_r <= ST_DONE;
        default: st_r <= ST_UNKNOWN;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      status       <= st_r;
      result_value <= result_reg;
    end
  end

  // arithmetic unit finishes only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_WAIT)
    else $error("arithmetic unit finished outside wait");

  // an accepted instruction moves on to the register read
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_READ)
    else $error("accepted instruction did not start");

  // a division by zero never writes the register file
  a_div0_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && st_r == ST_DIV0) |-> !$past(wr.en))
    else $error("register written on division by zero");

  // a new result is loaded only into a free output slot
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && out_stall) |=> $stable(result_value))
    else $error("waiting result overwritten");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for register_bytecode_executor: directed and random instructions
// with a predictor of the register file and the held result register
// depends on rbe_pkg and the register_bytecode_executor rtl
module testbench;
  import rbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // predicts each instruction and checks result transfers in order
  class instr_scoreboard;
    typedef struct {
      logic [1:0]            status;
      logic [DATA_WIDTH-1:0] value;
    } outcome_t;

    logic [DATA_WIDTH-1:0] regs [NUM_REGS];
    logic [DATA_WIDTH-1:0] held_result;
    outcome_t              pending[$];
    int                    errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      held_result = '0;
      errors = 0;
    endfunction

    // execute one accepted instruction on the predicted state
    function void note_instruction(logic [3:0] op, logic [11:0] bits);
      logic [REG_AW-1:0]     ra;
      logic [REG_AW-1:0]     rb;
      logic [REG_AW-1:0]     rc;
      logic [DATA_WIDTH-1:0] va;
      logic [DATA_WIDTH-1:0] vb;
      outcome_t              o;
      ra = bits[11:8];
      rb = bits[7:4];
      rc = bits[3:0];
      va = regs[ra];
      vb = regs[rb];
      o.status = ST_OK;
      case (op)
        OP_IMM:   regs[ra] = DATA_WIDTH'(bits[7:0]);
        OP_ADD:   regs[rc] = va + vb;
        OP_SUB:   regs[rc] = va - vb;
        OP_DIV: begin
          // a zero divisor leaves every register untouched
          if (vb == '0) o.status = ST_DIV0;
          else regs[rc] = va / vb;
        end
        OP_MUL:   regs[rc] = va * vb;
        OP_MOVE:  held_result = va;
        OP_DONE:  o.status = ST_DONE;
        default:  o.status = ST_UNKNOWN;
      endcase
      o.value = held_result;
      pending.push_back(o);
    endfunction

    // compare one result transfer against the oldest prediction
    function void check_result(logic [1:0] st, logic [DATA_WIDTH-1:0] v);
      outcome_t o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0d value %h", $time, st, v);
        errors++;
      end else begin
        o = pending.pop_front();
        if (st !== o.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, o.status, st);
          errors++;
        end
        if (v !== o.value) begin
          $display("%0t: result_value mismatch, expected %h actual %h", $time, o.value, v);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [3:0]            func;
  logic [11:0]           operand_bits;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] result_value;

  instr_scoreboard board;
  int              send_idle_pct;
  int              recv_idle_pct;

  register_bytecode_executor dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .operand_bits (operand_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value)
  );

  // clock
  always #10 clk = ~clk;

  // random backpressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      board.check_result(status, result_value);
    end
  end

  // one instruction transfer, with a random gap in front of it
  task automatic send_instruction(input logic [3:0] op, input logic [11:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= op;
    operand_bits <= bits;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_instruction(op, bits);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // random instruction stream, mostly well-formed with some unknown opcodes
  task automatic run_random(input int count);
    int          pick;
    logic [3:0]  op;
    logic [11:0] bits;
    logic [7:0]  imm;
    repeat (count) begin
      pick = $urandom_range(99);
      bits = 12'($urandom_range(4095));
      if (pick < 25) begin
        op = OP_IMM;
        // favor the immediate extremes so zero divisors and wide values show up
        case ($urandom_range(3))
          0:       imm = 8'h00;
          1:       imm = 8'hff;
          default: imm = 8'($urandom_range(255));
        endcase
        bits[7:0] = imm;
      end else if (pick < 40) op = OP_ADD;
      else if (pick < 55) op = OP_SUB;
      else if (pick < 67) op = OP_MUL;
      else if (pick < 79) op = OP_DIV;
      else if (pick < 91) op = OP_MOVE;
      else if (pick < 95) op = OP_DONE;
      else op = 4'($urandom_range(15, 7));
      send_instruction(op, bits);
    end
  endtask

  // main sequence
  initial begin
    board         = new();
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = '0;
    operand_bits  = '0;
    out_stall     = 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: immediates, wrap-around, wide products, divide corners
    send_instruction(OP_IMM,   12'h1ff);     // r1 = 0xff
    send_instruction(OP_IMM,   12'h200);     // r2 = 0
    send_instruction(OP_IMM,   12'hf80);     // r15 = 0x80
    send_instruction(OP_IMM,   12'h0ff);     // r0 = 0xff
    send_instruction(OP_ADD,   12'h113);     // r3 = r1 + r1
    send_instruction(OP_SUB,   12'h214);     // r4 = 0 - r1, wraps
    send_instruction(OP_MUL,   12'h445);     // r5 = r4 * r4, low half
    send_instruction(OP_MUL,   12'h416);     // r6 = r4 * r1
    send_instruction(OP_ADD,   12'h447);     // r7 = r4 + r4, carry out dropped
    send_instruction(OP_SUB,   12'h22e);     // r14 = 0 - 0
    send_instruction(OP_DIV,   12'h418);     // r8 = r4 / r1
    send_instruction(OP_DIV,   12'h129);     // divide by zero, r9 kept
    send_instruction(OP_DIV,   12'h14a);     // r10 = small / large = 0
    send_instruction(OP_DIV,   12'h44b);     // r11 = r4 / r4 = 1
    send_instruction(OP_MOVE,  12'h400);     // result = r4, the wrapped 0 - 0xff
    send_instruction(OP_DONE,  12'hfff);
    send_instruction(OP_MOVE,  12'h500);     // runs normally after done
    send_instruction(4'd7,     12'habc);     // lowest unknown opcode
    send_instruction(4'd15,    12'h123);     // highest unknown opcode
    send_instruction(OP_DIV,   12'h0e9);     // divide by a register that went to zero
    send_instruction(OP_MOVE,  12'hf00);     // result after an error
    send_instruction(OP_MUL,   12'h7f5);     // r5 = r7 * r15
    send_instruction(OP_MOVE,  12'h500);
    wait_for_results();

    // random phases with changing idle patterns
    run_random(600);
    wait_for_results();
    send_idle_pct = 79;
    recv_idle_pct = 12;
    run_random(575);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(575);
    wait_for_results();

    // catch any stray result transfer
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
